FILE: rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the buddy block allocator core.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_ORDER_DEF = 10;
  localparam int BS_W          = 21;
  localparam int MO_W          = 4;
  localparam int OFF_W         = 32;
  localparam int ORD_W         = 4;
  localparam int FREE_W        = 11;
  localparam int IN_TDATA_W    = 64;
  localparam int OUT_TDATA_W   = 48;
  localparam int FMW           = 32;
  localparam int DIV_CNT_W     = 5;

  localparam logic [BS_W-1:0] BS_RESET = 21'd16;
  localparam logic [MO_W-1:0] MO_RESET = 4'd10;

  typedef enum logic {
    CFG_BLOCK_SIZE = 1'b0,
    CFG_MAX_ORDER  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_ZERO    = 2'd2,
    ST_BADOFF  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_SWEEP,
    OP_LOAD,
    OP_DECODE,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_HIT,
    OP_SCAN_NEXTW,
    OP_SCAN_NEXTLVL,
    OP_SPL_RD,
    OP_SPL_WR,
    OP_FREE_START,
    OP_MRG_RD,
    OP_MRG_CLR,
    OP_SET_RD,
    OP_SET_WR,
    OP_RESULT
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_BR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SPL_CHK,
    S_SPL_WR,
    S_MRG_RD,
    S_MRG_CHK,
    S_SET_RD,
    S_SET_WR,
    S_RES
  } state_t;

  typedef struct packed {
    op_t     op;
    status_t st;
  } ctl_t;

  typedef struct packed {
    logic sweep_done;
    logic div_done;
    logic is_free;
    logic zero;
    logic too_big;
    logic fbad;
    logic ebad;
    logic hit;
    logic lvl_end;
    logic at_top;
    logic split_more;
    logic buddy_free;
    logic out_busy;
  } sts_t;

endpackage

FILE: rtl/core/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] wr_addr,
  input  logic [W-1:0]                      wr_data,
  input  logic                              rd_en,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] rd_addr,
  output logic [W-1:0]                      rd_data
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/bba_div.sv
// ----------------------------------------------------------------------------
// bba_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bba_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bba_pkg::OFF_W-1:0] dividend,
  input  logic [bba_pkg::BS_W-1:0]  divisor,
  output logic                      busy,
  output logic [bba_pkg::OFF_W-1:0] quo,
  output logic [bba_pkg::BS_W-1:0]  rem
);
  import bba_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OFF_W-1:0]     quo_r, quo_nxt;
  logic [BS_W-1:0]      rem_r, rem_nxt;
  logic [BS_W:0]        sh;
  logic [BS_W:0]        diff;

  always_comb begin
    sh       = {rem_r, quo_r[OFF_W-1]};
    diff     = sh - {1'b0, divisor};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (sh >= {1'b0, divisor}) begin
        rem_nxt = diff[BS_W-1:0];
        quo_nxt = {quo_r[OFF_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[BS_W-1:0];
        quo_nxt = {quo_r[OFF_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (&cnt_r) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/core/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: clearing pass, divide, search, split, merge.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          cfg_we,
  input  bba_pkg::sts_t sts,
  output bba_pkg::ctl_t ctl
);
  import bba_pkg::*;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    case (state_r)
      S_CLEAR: begin
        if (!cfg_we && sts.sweep_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_BR;
      end
      S_BR: begin
        if (!sts.is_free) begin
          if (sts.zero) begin
            st_nxt    = ST_ZERO;
            state_nxt = S_RES;
          end else if (sts.too_big) begin
            st_nxt    = ST_NOSPACE;
            state_nxt = S_RES;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end else if (sts.fbad || sts.ebad) begin
          st_nxt    = ST_BADOFF;
          state_nxt = S_RES;
        end else begin
          state_nxt = S_MRG_RD;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (sts.hit) begin
          state_nxt = S_SPL_CHK;
        end else if (sts.lvl_end && sts.at_top) begin
          st_nxt    = ST_NOSPACE;
          state_nxt = S_RES;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SPL_CHK: begin
        if (sts.split_more) begin
          state_nxt = S_SPL_WR;
        end else begin
          st_nxt    = ST_OK;
          state_nxt = S_RES;
        end
      end
      S_SPL_WR: state_nxt = S_SPL_CHK;
      S_MRG_RD: begin
        if (sts.at_top) state_nxt = S_SET_RD;
        else            state_nxt = S_MRG_CHK;
      end
      S_MRG_CHK: begin
        if (sts.buddy_free) state_nxt = S_MRG_RD;
        else                state_nxt = S_SET_RD;
      end
      S_SET_RD: state_nxt = S_SET_WR;
      S_SET_WR: begin
        st_nxt    = ST_OK;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
    if (cfg_we) state_nxt = S_CLEAR;
  end

  always_comb begin
    ctl.op    = OP_IDLE;
    ctl.st    = st_r;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: ctl.op = OP_SWEEP;
      S_IDLE: begin
        in_tready = !cfg_we;
        if (in_tvalid && !cfg_we) ctl.op = OP_LOAD;
      end
      S_DIV: begin
        if (sts.div_done) ctl.op = OP_DECODE;
      end
      S_BR: begin
        if (!sts.is_free) begin
          if (!sts.zero && !sts.too_big) ctl.op = OP_SCAN_INIT;
        end else if (!sts.fbad && !sts.ebad) begin
          ctl.op = OP_FREE_START;
        end
      end
      S_SCAN_RD: ctl.op = OP_SCAN_RD;
      S_SCAN_CHK: begin
        if (sts.hit)            ctl.op = OP_SCAN_HIT;
        else if (!sts.lvl_end)  ctl.op = OP_SCAN_NEXTW;
        else if (!sts.at_top)   ctl.op = OP_SCAN_NEXTLVL;
      end
      S_SPL_CHK: begin
        if (sts.split_more) ctl.op = OP_SPL_RD;
      end
      S_SPL_WR: ctl.op = OP_SPL_WR;
      S_MRG_RD: begin
        if (!sts.at_top) ctl.op = OP_MRG_RD;
      end
      S_MRG_CHK: begin
        if (sts.buddy_free) ctl.op = OP_MRG_CLR;
      end
      S_SET_RD: ctl.op = OP_SET_RD;
      S_SET_WR: ctl.op = OP_SET_WR;
      S_RES: begin
        if (!sts.out_busy) ctl.op = OP_RESULT;
      end
      default: ctl.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

FILE: rtl/core/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// Config registers, divider, free map and allocation table memories, search,
// split and merge registers, and the result register.
// ----------------------------------------------------------------------------
module bba_datapath #(
  parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  bba_pkg::cfg_idx_t               cfg_addr,
  input  logic [bba_pkg::BS_W-1:0]        cfg_wdata,
  input  logic                            in_tuser,
  input  logic [bba_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bba_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]                      out_tuser,
  input  bba_pkg::ctl_t                   ctl,
  output bba_pkg::sts_t                   sts
);
  import bba_pkg::*;

  localparam int AW  = (MAX_ORDER > 0) ? MAX_ORDER : 1;
  localparam int NW  = (MAX_ORDER + 1 > 6) ? MAX_ORDER + 1 : 6;
  localparam int FAW = NW - 5;
  localparam int CW  = MAX_ORDER + 1;
  localparam logic [4:0] MO_LIM = 5'(MAX_ORDER);

  function automatic logic [NW-1:0] node_of(input logic [3:0] mo, input logic [3:0] o,
                                            input logic [AW-1:0] b);
    node_of = (NW'(1) << (mo - o)) + NW'(b >> o);
  endfunction

  function automatic logic [FAW-1:0] first_word(input logic [3:0] mo, input logic [3:0] k);
    logic [NW-1:0] t;
    t = NW'(1) << (mo - k);
    first_word = t[NW-1:5];
  endfunction

  logic [BS_W-1:0]  bs_r;
  logic [MO_W-1:0]  mo_r;
  logic [MO_W-1:0]  mo_eff;
  logic [BS_W-1:0]  bs_eff;

  logic             cmd_r;
  logic             zero_r;
  logic [5:0]       need_r, need_nxt;
  logic [4:0]       lvl_r;
  logic [AW-1:0]    blk_r;
  logic [FAW-1:0]   word_r;
  logic [NW-1:0]    node_r;
  logic [3:0]       ord_r;
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    swp_r;

  logic             out_valid_r;
  status_t          out_st_r;
  logic [OFF_W-1:0] out_off_r;
  logic [ORD_W-1:0] out_ord_r;
  logic [FREE_W-1:0] out_free_r;

  logic [OFF_W-1:0] quo;
  logic [BS_W-1:0]  rem;
  logic             div_busy;
  logic [OFF_W-1:0] nblk_m1;

  logic [NW-1:0]    base;
  logic [NW:0]      last_t;
  logic [FMW-1:0]   lvl_mask;
  logic [FMW-1:0]   masked;
  logic [4:0]       idx;
  logic [NW-1:0]    hit_node;
  logic [NW-1:0]    hit_j;
  logic [AW-1:0]    hit_blk;
  logic [3:0]       lvl_m1;
  logic [3:0]       ent_ord;
  logic [AW+BS_W-1:0] prod;
  logic [31:0]      cnt32;
  logic [NW-1:0]    node_sel;

  logic             fm_we, fm_re;
  logic [FAW-1:0]   fm_waddr, fm_raddr;
  logic [FMW-1:0]   fm_wdata, fm_rd;
  logic             at_we, at_re;
  logic [AW-1:0]    at_waddr;
  logic [4:0]       at_wdata, at_rd;

  assign mo_eff = ({1'b0, mo_r} > MO_LIM) ? MO_LIM[3:0] : mo_r;
  assign bs_eff = (bs_r[BS_W-1:4] == '0) ? BS_W'(16) : {bs_r[BS_W-1:4], 4'b0000};

  bba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.op == OP_LOAD),
    .dividend (in_tuser ? in_tdata[63:32] : in_tdata[31:0]),
    .divisor  (bs_eff),
    .busy     (div_busy),
    .quo      (quo),
    .rem      (rem)
  );

  bba_ram #(.W(FMW), .D(1 << FAW)) u_free_map (
    .clk     (clk),
    .wr_en   (fm_we),
    .wr_addr (fm_waddr),
    .wr_data (fm_wdata),
    .rd_en   (fm_re),
    .rd_addr (fm_raddr),
    .rd_data (fm_rd)
  );

  bba_ram #(.W(5), .D(1 << AW)) u_alloc_tbl (
    .clk     (clk),
    .wr_en   (at_we),
    .wr_addr (at_waddr),
    .wr_data (at_wdata),
    .rd_en   (at_re),
    .rd_addr (quo[AW-1:0]),
    .rd_data (at_rd)
  );

  always_comb begin
    nblk_m1  = quo + OFF_W'(rem != '0) - OFF_W'(1);
    need_nxt = '0;
    for (int i = 0; i < OFF_W; i++) begin
      if (nblk_m1[i]) need_nxt = 6'(i + 1);
    end
  end

  always_comb begin
    base   = NW'(1) << (mo_eff - lvl_r[3:0]);
    last_t = {base, 1'b0} - (NW+1)'(1);
    for (int i = 0; i < FMW; i++) begin
      lvl_mask[i] = (|base[NW-1:5]) ||
                    (((NW+1)'(i) >= {1'b0, base}) && ((NW+1)'(i) < {base, 1'b0}));
    end
    masked = fm_rd & lvl_mask;
    idx    = '0;
    for (int i = FMW - 1; i >= 0; i--) begin
      if (masked[i]) idx = 5'(i);
    end
    hit_node = {word_r, idx};
    hit_j    = hit_node - base;
    hit_blk  = AW'(32'(hit_j) << lvl_r);
    lvl_m1   = 4'(lvl_r - 5'd1);
    ent_ord  = 4'(at_rd - 5'd1);
    prod     = blk_r * bs_eff;
    cnt32    = 32'(count_r);
  end

  always_comb begin
    node_sel = node_r;
    case (ctl.op)
      OP_SPL_RD: node_sel = node_of(mo_eff, lvl_m1, blk_r + (AW'(1) << lvl_m1));
      OP_MRG_RD: node_sel = node_of(mo_eff, lvl_r[3:0], blk_r ^ (AW'(1) << lvl_r[3:0]));
      OP_SET_RD: node_sel = node_of(mo_eff, lvl_r[3:0], blk_r);
      default:   node_sel = node_r;
    endcase
  end

  always_comb begin
    fm_we    = 1'b0;
    fm_waddr = node_r[NW-1:5];
    fm_wdata = fm_rd;
    fm_re    = 1'b0;
    fm_raddr = node_sel[NW-1:5];
    at_we    = 1'b0;
    at_waddr = blk_r;
    at_wdata = '0;
    at_re    = 1'b0;
    case (ctl.op)
      OP_SWEEP: begin
        fm_we    = 1'b1;
        fm_waddr = swp_r[FAW-1:0];
        fm_wdata = (swp_r[FAW-1:0] == '0) ? FMW'(2) : '0;
        at_we    = 1'b1;
        at_waddr = swp_r;
      end
      OP_DECODE: at_re = 1'b1;
      OP_SCAN_RD: begin
        fm_re    = 1'b1;
        fm_raddr = word_r;
      end
      OP_SCAN_HIT: begin
        fm_we    = 1'b1;
        fm_waddr = word_r;
        fm_wdata = fm_rd & ~(FMW'(1) << idx);
        at_we    = 1'b1;
        at_waddr = hit_blk;
        at_wdata = 5'(need_r) + 5'd1;
      end
      OP_SPL_RD, OP_MRG_RD, OP_SET_RD: fm_re = 1'b1;
      OP_SPL_WR, OP_SET_WR: begin
        fm_we    = 1'b1;
        fm_wdata = fm_rd | (FMW'(1) << node_r[4:0]);
      end
      OP_MRG_CLR: begin
        fm_we    = 1'b1;
        fm_wdata = fm_rd & ~(FMW'(1) << node_r[4:0]);
      end
      OP_FREE_START: begin
        at_we    = 1'b1;
        at_waddr = quo[AW-1:0];
      end
      default: fm_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r        <= BS_RESET;
      mo_r        <= MO_RESET;
      swp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        swp_r <= '0;
        if (cfg_addr == CFG_BLOCK_SIZE) bs_r <= cfg_wdata;
        else                            mo_r <= cfg_wdata[MO_W-1:0];
      end else if (ctl.op == OP_SWEEP) begin
        swp_r <= swp_r + 1'b1;
      end
      if (ctl.op == OP_RESULT)  out_valid_r <= 1'b1;
      else if (out_tready)      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_SWEEP: count_r <= CW'(1) << mo_eff;
      OP_LOAD: begin
        cmd_r  <= in_tuser;
        zero_r <= (in_tdata[31:0] == '0);
      end
      OP_DECODE: need_r <= need_nxt;
      OP_SCAN_INIT: begin
        lvl_r  <= need_r[4:0];
        word_r <= first_word(mo_eff, need_r[3:0]);
      end
      OP_SCAN_NEXTW: word_r <= word_r + 1'b1;
      OP_SCAN_NEXTLVL: begin
        lvl_r  <= lvl_r + 5'd1;
        word_r <= first_word(mo_eff, 4'(lvl_r + 5'd1));
      end
      OP_SCAN_HIT: begin
        blk_r   <= hit_blk;
        count_r <= count_r - (CW'(1) << need_r);
      end
      OP_SPL_RD: begin
        lvl_r  <= 5'(lvl_m1);
        node_r <= node_sel;
      end
      OP_MRG_RD, OP_SET_RD: node_r <= node_sel;
      OP_MRG_CLR: begin
        blk_r <= blk_r & ~(AW'(1) << lvl_r[3:0]);
        lvl_r <= lvl_r + 5'd1;
      end
      OP_FREE_START: begin
        lvl_r   <= 5'(ent_ord);
        ord_r   <= ent_ord;
        blk_r   <= quo[AW-1:0];
        count_r <= count_r + (CW'(1) << ent_ord);
      end
      OP_RESULT: begin
        out_st_r   <= ctl.st;
        out_free_r <= cnt32[FREE_W-1:0];
        if (ctl.st == ST_OK && cmd_r) begin
          out_off_r <= '0;
          out_ord_r <= ord_r;
        end else if (ctl.st == ST_OK) begin
          out_off_r <= OFF_W'(prod);
          out_ord_r <= need_r[3:0];
        end else begin
          out_off_r <= '0;
          out_ord_r <= '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.sweep_done = &swp_r;
    sts.div_done   = !div_busy;
    sts.is_free    = cmd_r;
    sts.zero       = zero_r;
    sts.too_big    = need_r > {2'b00, mo_eff};
    sts.fbad       = (rem != '0) || ((quo >> mo_eff) != '0);
    sts.ebad       = (at_rd == '0) || ((at_rd - 5'd1) > {1'b0, mo_eff});
    sts.hit        = |masked;
    sts.lvl_end    = ({1'b0, word_r} == last_t[NW:5]);
    sts.at_top     = lvl_r >= {1'b0, mo_eff};
    sts.split_more = {1'b0, lvl_r} > need_r;
    sts.buddy_free = fm_rd[node_r[4:0]];
    sts.out_busy   = out_valid_r && !out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_free_r, out_ord_r, out_off_r};
  assign out_tuser  = out_st_r;

endmodule

FILE: rtl/core/buddy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Binary buddy allocator over 2^max_order blocks of block_size bytes.
// ----------------------------------------------------------------------------
// One item at a time. Each item first runs a restoring divider
// (byte count or byte offset by block size), then its search or merge:
// an allocate scans 32-node free map words from the requested order
// upward and then splits; a free runs its merge steps. A result that
// waits on out_tready holds the next item back. The free map is read and
// written a word at a time through one read and one write RAM port, which
// sets the search cost. After reset and after any register write a
// clearing pass over 2^MAX_ORDER table entries (1024 by default) rebuilds
// the tables; no item is accepted during it. The result register frees
// the input side as soon as the result is loaded.
module buddy_block_allocator_core #(
  parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  bba_pkg::cfg_idx_t               cfg_addr,
  input  logic [bba_pkg::BS_W-1:0]        cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bba_pkg::IN_TDATA_W-1:0]  in_tdata,   // nbytes, offset
  input  logic                            in_tuser,   // cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bba_pkg::OUT_TDATA_W-1:0] out_tdata,  // block_offset, block_order,
                                                      // free_blocks
  output logic [1:0]                      out_tuser   // status
);
  import bba_pkg::*;

  ctl_t ctl;
  sts_t sts;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_we    (cfg_we),
    .sts       (sts),
    .ctl       (ctl)
  );

  bba_datapath #(.MAX_ORDER(MAX_ORDER)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .ctl        (ctl),
    .sts        (sts)
  );

endmodule
